// ----- design/bcr_pkg.sv -----
// Shared types, constants and the arctangent table for the BPSK Costas loop.
// Used by bcr_ctrl, bcr_datapath and the top level; no dependencies.
package bcr_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int LANES         = 4;
   localparam int PHASE_BITS    = 24;
   localparam int TABLE_BITS    = 10;
   localparam int CORDIC_STEPS  = 24;
   localparam int ERR_FRAC      = 30;
   localparam int LANE_W        = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int SUM_W         = 2 * SAMPLE_BITS + 2;
   localparam int STEP_W        = $clog2(CORDIC_STEPS);
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 25;
   localparam int PGAIN_W       = 20;
   localparam int FGAIN_W       = 16;
   localparam int MAXDEV_W      = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEV    = 2'd2;

   localparam logic [PGAIN_W-1:0]  PHASE_GAIN_RST = 20'd37496;
   localparam logic [FGAIN_W-1:0]  FREQ_GAIN_RST  = 16'd265;
   localparam logic [MAXDEV_W-1:0] MAX_DEV_RST    = 25'd16777216;

   typedef enum logic [3:0] {
      S_IDLE, S_ANGLE, S_ROT, S_MUL, S_SAT, S_PDET, S_PACC,
      S_ERR, S_GAINF, S_GAINP, S_UPD, S_PUSH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_ANG_INIT, OP_ROT, OP_MUL, OP_SAT, OP_PDET, OP_PACC,
      OP_ERR, OP_GAINF, OP_GAINP, OP_UPD, OP_PUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic [LANE_W-1:0]  lane;
      logic [STEP_W-1:0]  step;
      logic [2:0]         mstep;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/bcr_ctrl.sv -----
// Sequencer for the Costas loop: walks lanes, CORDIC steps and the loop update.
// Depends on bcr_pkg; drives bcr_datapath through cmd_type.
module bcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bcr_pkg::status_type status,
   output bcr_pkg::cmd_type    cmd
);

   bcr_pkg::state_type state_ff, state_in;
   logic [bcr_pkg::LANE_W-1:0] lane_ff, lane_in;
   logic [bcr_pkg::STEP_W-1:0] step_ff, step_in;
   logic [2:0]                 mstep_ff, mstep_in;
   logic                       last_lane;

   assign last_lane = (lane_ff == bcr_pkg::LANE_W'(bcr_pkg::LANES - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcr_pkg::S_IDLE:  if (req_valid) state_in = bcr_pkg::S_ANGLE;
         bcr_pkg::S_ANGLE: state_in = bcr_pkg::S_ROT;
         bcr_pkg::S_ROT: begin
            if (step_ff == bcr_pkg::STEP_W'(bcr_pkg::CORDIC_STEPS - 1))
               state_in = bcr_pkg::S_MUL;
         end
         bcr_pkg::S_MUL:   if (mstep_ff == 3'd4) state_in = bcr_pkg::S_SAT;
         bcr_pkg::S_SAT:   state_in = bcr_pkg::S_PDET;
         bcr_pkg::S_PDET:  state_in = bcr_pkg::S_PACC;
         bcr_pkg::S_PACC:  state_in = last_lane ? bcr_pkg::S_ERR : bcr_pkg::S_ANGLE;
         bcr_pkg::S_ERR:   state_in = bcr_pkg::S_GAINF;
         bcr_pkg::S_GAINF: state_in = bcr_pkg::S_GAINP;
         bcr_pkg::S_GAINP: state_in = bcr_pkg::S_UPD;
         bcr_pkg::S_UPD:   state_in = bcr_pkg::S_PUSH;
         bcr_pkg::S_PUSH:  if (status.out_free) state_in = bcr_pkg::S_IDLE;
         default:          state_in = bcr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      lane_in  = lane_ff;
      step_in  = step_ff;
      mstep_in = mstep_ff;
      unique case (state_ff)
         bcr_pkg::S_IDLE:  lane_in = '0;
         bcr_pkg::S_ANGLE: begin
            step_in  = '0;
            mstep_in = '0;
         end
         bcr_pkg::S_ROT:   step_in = step_ff + 1'b1;
         bcr_pkg::S_MUL:   mstep_in = mstep_ff + 3'd1;
         bcr_pkg::S_PACC:  lane_in = lane_ff + 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      cmd.lane  = lane_ff;
      cmd.step  = step_ff;
      cmd.mstep = mstep_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         bcr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = req_valid ? bcr_pkg::OP_LOAD : bcr_pkg::OP_NONE;
         end
         bcr_pkg::S_ANGLE: cmd.op = bcr_pkg::OP_ANG_INIT;
         bcr_pkg::S_ROT:   cmd.op = bcr_pkg::OP_ROT;
         bcr_pkg::S_MUL:   cmd.op = bcr_pkg::OP_MUL;
         bcr_pkg::S_SAT:   cmd.op = bcr_pkg::OP_SAT;
         bcr_pkg::S_PDET:  cmd.op = bcr_pkg::OP_PDET;
         bcr_pkg::S_PACC:  cmd.op = bcr_pkg::OP_PACC;
         bcr_pkg::S_ERR:   cmd.op = bcr_pkg::OP_ERR;
         bcr_pkg::S_GAINF: cmd.op = bcr_pkg::OP_GAINF;
         bcr_pkg::S_GAINP: cmd.op = bcr_pkg::OP_GAINP;
         bcr_pkg::S_UPD:   cmd.op = bcr_pkg::OP_UPD;
         bcr_pkg::S_PUSH:  cmd.op = bcr_pkg::OP_PUSH;
         default:          cmd.op = bcr_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcr_pkg::S_IDLE;
         lane_ff  <= '0;
         step_ff  <= '0;
         mstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
         step_ff  <= step_in;
         mstep_ff <= mstep_in;
      end
   end

endmodule

// ----- design/bcr_datapath.sv -----
// Datapath: sample store, shared CORDIC rotator, shared multiplier, lane average,
// loop filter state, configuration registers and output register. Uses bcr_pkg.
module bcr_datapath #(
   parameter int PHASE_BITS = bcr_pkg::PHASE_BITS,
   parameter int TABLE_BITS = bcr_pkg::TABLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bcr_pkg::cmd_type                       cmd,
   output bcr_pkg::status_type                    status,
   input  logic                                   csr_valid,
   input  logic [bcr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [bcr_pkg::CSR_DATA_W-1:0]         csr_data,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] item_re [bcr_pkg::LANES],
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] item_im [bcr_pkg::LANES],
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] res_re [bcr_pkg::LANES],
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] res_im [bcr_pkg::LANES],
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready
);

   localparam int SB    = bcr_pkg::SAMPLE_BITS;
   localparam int NL    = bcr_pkg::LANES;
   localparam int AW    = 33;
   localparam int MB    = ((SB > 21) ? SB : 21) + 1;
   localparam int PW    = AW + MB;
   localparam int PF    = 2 * (SB - 1);
   localparam int SW    = bcr_pkg::SUM_W;
   localparam int DSH   = $clog2(NL);
   localparam int FW    = PHASE_BITS + 3;
   localparam int QW    = PHASE_BITS + 2;
   localparam int CW    = ((FW > 26) ? FW : 26) + 1;
   localparam int CXW   = 34;
   localparam int SH_R  = (PF >= bcr_pkg::ERR_FRAC) ? PF - bcr_pkg::ERR_FRAC : 0;
   localparam int SH_L  = (PF >= bcr_pkg::ERR_FRAC) ? 0 : bcr_pkg::ERR_FRAC - PF;
   localparam int EXW   = SW + 16;

   localparam logic signed [CXW-1:0] CX_ONE   = CXW'(64'sd1 <<< 30);
   localparam logic signed [CXW-1:0] CX_START = CXW'(64'sd652032874);
   localparam logic signed [PW-1:0]  P_ONE    = PW'(64'sd1) <<< PF;
   localparam logic signed [PW:0]    RND_HALF = (PW+1)'(64'sd1 <<< 29);
   localparam logic signed [PW:0]    S_HI     = (PW+1)'((64'sd1 <<< (SB - 1)) - 1);
   localparam logic signed [PW:0]    S_LO     = -S_HI - 1;
   localparam logic signed [CW-1:0]  LIM_MAX  = CW'((65'sd1 <<< (PHASE_BITS + 1)) - 1);

   logic [bcr_pkg::PGAIN_W-1:0]  pgain_ff;
   logic [bcr_pkg::FGAIN_W-1:0]  fgain_ff;
   logic [bcr_pkg::MAXDEV_W-1:0] maxdev_ff;
   logic [PHASE_BITS-1:0]        phase_ff, phase_in;
   logic signed [QW-1:0]         freq_ff, freq_in;

   logic signed [SB-1:0]   in_re_ff [NL];
   logic signed [SB-1:0]   in_im_ff [NL];
   logic signed [SB-1:0]   lane_re_ff [NL];
   logic signed [SB-1:0]   lane_im_ff [NL];
   logic signed [SB-1:0]   out_re_ff [NL];
   logic signed [SB-1:0]   out_im_ff [NL];
   logic                   rsp_valid_ff;

   logic [PHASE_BITS-1:0]  angle_ff;
   logic signed [CXW-1:0]  cx_ff, cy_ff, cz_ff;
   logic                   flip_ff;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [PW:0]     acc_re_ff, acc_im_ff;
   logic signed [SB-1:0]   dre_ff, dim_ff;
   logic signed [SW-1:0]   sum_ff;
   logic signed [31:0]     err_ff;
   logic signed [FW-1:0]   fnew_ff;

   logic [PHASE_BITS-1:0]  neg_ang;
   logic [31:0]            ang32, ang_f;
   logic                   flip_c;
   logic signed [CXW-1:0]  dx, dy, at_v, cx_cl, cy_cl;
   logic signed [31:0]     c_v, s_v;
   logic signed [AW-1:0]   mul_a;
   logic signed [MB-1:0]   mul_b;
   logic signed [SB-1:0]   sel_re, sel_im, sat_re, sat_im;
   logic signed [PW:0]     rnd_re, rnd_im;
   logic signed [PW-1:0]   pclip;
   logic signed [SW-1:0]   avg;
   logic signed [EXW-1:0]  err_ext;
   logic signed [CW-1:0]   fn_c, lim, md_c, fclamp;

   assign sel_re = in_re_ff[cmd.lane];
   assign sel_im = in_im_ff[cmd.lane];

   assign neg_ang = -angle_ff;
   assign ang32   = {neg_ang[PHASE_BITS-1 -: TABLE_BITS], {(32-TABLE_BITS){1'b0}}};
   assign flip_c  = ang32[31] ^ ang32[30];
   assign ang_f   = {ang32[31] ^ flip_c, ang32[30:0]};

   assign dx   = cy_ff >>> cmd.step;
   assign dy   = cx_ff >>> cmd.step;
   assign at_v = CXW'(bcr_pkg::atan_val(cmd.step));

   always_comb begin
      cx_cl = cx_ff;
      cy_cl = cy_ff;
      if (cx_ff > CX_ONE) cx_cl = CX_ONE;
      if (cx_ff < -CX_ONE) cx_cl = -CX_ONE;
      if (cy_ff > CX_ONE) cy_cl = CX_ONE;
      if (cy_ff < -CX_ONE) cy_cl = -CX_ONE;
      c_v = flip_ff ? 32'(-cx_cl) : 32'(cx_cl);
      s_v = flip_ff ? 32'(-cy_cl) : 32'(cy_cl);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         bcr_pkg::OP_MUL: begin
            unique case (cmd.mstep)
               3'd0: begin mul_a = AW'(c_v); mul_b = MB'(sel_re); end
               3'd1: begin mul_a = AW'(s_v); mul_b = MB'(sel_im); end
               3'd2: begin mul_a = AW'(s_v); mul_b = MB'(sel_re); end
               3'd3: begin mul_a = AW'(c_v); mul_b = MB'(sel_im); end
               default: ;
            endcase
         end
         bcr_pkg::OP_PDET:  begin mul_a = AW'(dre_ff); mul_b = MB'(dim_ff); end
         bcr_pkg::OP_GAINF: begin mul_a = AW'(err_ff); mul_b = MB'(fgain_ff); end
         bcr_pkg::OP_GAINP: begin mul_a = AW'(err_ff); mul_b = MB'(pgain_ff); end
         default: ;
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      rnd_re = (acc_re_ff + RND_HALF) >>> 30;
      rnd_im = (acc_im_ff + RND_HALF) >>> 30;
      if (rnd_re > S_HI)      sat_re = SB'(S_HI);
      else if (rnd_re < S_LO) sat_re = SB'(S_LO);
      else                    sat_re = SB'(rnd_re);
      if (rnd_im > S_HI)      sat_im = SB'(S_HI);
      else if (rnd_im < S_LO) sat_im = SB'(S_LO);
      else                    sat_im = SB'(rnd_im);
   end

   always_comb begin
      pclip = prod_ff;
      if (prod_ff > P_ONE)  pclip = P_ONE;
      if (prod_ff < -P_ONE) pclip = -P_ONE;
   end

   always_comb begin
      avg     = sum_ff >>> DSH;
      err_ext = (EXW'(avg) >>> SH_R) <<< SH_L;
   end

   always_comb begin
      phase_in = phase_ff + PHASE_BITS'(prod_ff >>> bcr_pkg::ERR_FRAC)
                 + PHASE_BITS'(fnew_ff);
      fn_c = CW'(fnew_ff);
      md_c = CW'({1'b0, maxdev_ff});
      lim  = (md_c > LIM_MAX) ? LIM_MAX : md_c;
      if (fn_c > lim)       fclamp = lim;
      else if (fn_c < -lim) fclamp = -lim;
      else                  fclamp = fn_c;
      freq_in = QW'(fclamp);
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign res_re          = out_re_ff;
   assign res_im          = out_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pgain_ff     <= bcr_pkg::PHASE_GAIN_RST;
         fgain_ff     <= bcr_pkg::FREQ_GAIN_RST;
         maxdev_ff    <= bcr_pkg::MAX_DEV_RST;
         phase_ff     <= '0;
         freq_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               bcr_pkg::CSR_PHASE_GAIN: pgain_ff  <= bcr_pkg::PGAIN_W'(csr_data);
               bcr_pkg::CSR_FREQ_GAIN:  fgain_ff  <= bcr_pkg::FGAIN_W'(csr_data);
               bcr_pkg::CSR_MAX_DEV:    maxdev_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.op == bcr_pkg::OP_UPD) begin
            phase_ff <= phase_in;
            freq_ff  <= freq_in;
         end
         if (cmd.op == bcr_pkg::OP_PUSH && status.out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                                  rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.op)
         bcr_pkg::OP_LOAD: begin
            in_re_ff <= item_re;
            in_im_ff <= item_im;
            angle_ff <= phase_ff;
            sum_ff   <= '0;
         end
         bcr_pkg::OP_ANG_INIT: begin
            cx_ff   <= CX_START;
            cy_ff   <= '0;
            cz_ff   <= CXW'(signed'(ang_f));
            flip_ff <= flip_c;
         end
         bcr_pkg::OP_ROT: begin
            if (cz_ff >= 0) begin
               cx_ff <= cx_ff - dx;
               cy_ff <= cy_ff + dy;
               cz_ff <= cz_ff - at_v;
            end else begin
               cx_ff <= cx_ff + dx;
               cy_ff <= cy_ff - dy;
               cz_ff <= cz_ff + at_v;
            end
         end
         bcr_pkg::OP_MUL: begin
            unique case (cmd.mstep)
               3'd1: acc_re_ff <= (PW+1)'(prod_ff);
               3'd2: acc_re_ff <= acc_re_ff - (PW+1)'(prod_ff);
               3'd3: acc_im_ff <= (PW+1)'(prod_ff);
               3'd4: acc_im_ff <= acc_im_ff + (PW+1)'(prod_ff);
               default: ;
            endcase
         end
         bcr_pkg::OP_SAT: begin
            dre_ff              <= sat_re;
            dim_ff              <= sat_im;
            lane_re_ff[cmd.lane] <= sat_re;
            lane_im_ff[cmd.lane] <= sat_im;
         end
         bcr_pkg::OP_PACC: begin
            sum_ff   <= sum_ff + SW'(pclip);
            angle_ff <= angle_ff + PHASE_BITS'(freq_ff);
         end
         bcr_pkg::OP_ERR:   err_ff  <= 32'(err_ext);
         bcr_pkg::OP_GAINP: fnew_ff <= FW'(freq_ff) + FW'(prod_ff >>> bcr_pkg::ERR_FRAC);
         bcr_pkg::OP_PUSH: begin
            if (status.out_free) begin
               out_re_ff <= lane_re_ff;
               out_im_ff <= lane_im_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- design/bpsk_costas_carrier_recovery.sv -----
// BPSK Costas carrier recovery: one transaction of four samples in, one out.
// From accept to rsp_valid: per lane an angle load, 24 CORDIC steps, multiply steps,
// saturate, detect and accumulate, then the error, gain, update and push states.
// A new transaction is taken only after the last is pushed; req_ready is high only
// when idle, and a result held by a low rsp_ready stalls the push of the next one.
// Synchronous active-high reset clears loop phase and frequency and loads default gains.
module bpsk_costas_carrier_recovery #(
   parameter int PHASE_BITS = bcr_pkg::PHASE_BITS,
   parameter int TABLE_BITS = bcr_pkg::TABLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] req_in_re0,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] req_in_im0,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] req_in_re1,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] req_in_im1,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] req_in_re2,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] req_in_im2,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] req_in_re3,
   input  logic signed [bcr_pkg::SAMPLE_BITS-1:0] req_in_im3,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_re0,
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_im0,
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_re1,
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_im1,
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_re2,
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_im2,
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_re3,
   output logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_im3,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bcr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [bcr_pkg::CSR_DATA_W-1:0]         csr_data
);

   bcr_pkg::cmd_type    cmd;
   bcr_pkg::status_type status;

   logic signed [bcr_pkg::SAMPLE_BITS-1:0] item_re [bcr_pkg::LANES];
   logic signed [bcr_pkg::SAMPLE_BITS-1:0] item_im [bcr_pkg::LANES];
   logic signed [bcr_pkg::SAMPLE_BITS-1:0] res_re  [bcr_pkg::LANES];
   logic signed [bcr_pkg::SAMPLE_BITS-1:0] res_im  [bcr_pkg::LANES];

   assign csr_ready = 1'b1;

   assign item_re[0] = req_in_re0;
   assign item_im[0] = req_in_im0;
   assign item_re[1] = req_in_re1;
   assign item_im[1] = req_in_im1;
   assign item_re[2] = req_in_re2;
   assign item_im[2] = req_in_im2;
   assign item_re[3] = req_in_re3;
   assign item_im[3] = req_in_im3;

   assign rsp_out_re0 = res_re[0];
   assign rsp_out_im0 = res_im[0];
   assign rsp_out_re1 = res_re[1];
   assign rsp_out_im1 = res_im[1];
   assign rsp_out_re2 = res_re[2];
   assign rsp_out_im2 = res_im[2];
   assign rsp_out_re3 = res_re[3];
   assign rsp_out_im3 = res_im[3];

   bcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcr_datapath #(
      .PHASE_BITS (PHASE_BITS),
      .TABLE_BITS (TABLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .item_re   (item_re),
      .item_im   (item_im),
      .res_re    (res_re),
      .res_im    (res_im),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

// ----- design/bcr_checker.sv -----
// Port-level checks for bpsk_costas_carrier_recovery, attached with bind.
// Depends on bcr_pkg for field widths.
module bcr_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_re0,
   input logic signed [bcr_pkg::SAMPLE_BITS-1:0] rsp_out_im3
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_re0) && $stable(rsp_out_im3))
      else $error("rsp payload changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared right after accept");

endmodule

bind bpsk_costas_carrier_recovery bcr_checker u_bcr_checker (.*);
